@@ hw/rtl/nnis_pkg.sv @@
// Shared constants for the nearest-neighbor image scaler.
`timescale 1ns / 1ps

package nnis_pkg;

  // Default build limits
  localparam int NNIS_MAX_WIDTH  = 2048;
  localparam int NNIS_MAX_FACTOR = 8;

  // Payload widths
  localparam int CHAN_W = 8;
  localparam int PIX_W  = 3 * CHAN_W;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int MODE_W     = 2;
  localparam int FACTOR_W   = 4;
  localparam int WIDTH_W    = 12;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd2;

  // Register reset values
  localparam logic [MODE_W-1:0]   MODE_RST   = 2'd0;
  localparam logic [FACTOR_W-1:0] FACTOR_RST = 4'd2;
  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 12'd640;

  // Scale modes; the unused code behaves as copy
  localparam logic [MODE_W-1:0] MODE_COPY    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ENLARGE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SHRINK  = 2'd2;

  // Input word opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

endpackage

@@ hw/rtl/nearest_neighbor_image_scaler.sv @@
// Nearest-neighbor integer image scaler: copy, enlarge and shrink of RGB raster words.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid/in_ready): one word per pixel in raster order, or a
//   flush word (in_opcode = 1) that drains the last stored row in enlarge mode.
//   Output channel (out_valid/out_ready): RGB pixels with row_end on the last
//   pixel of each output row and run_last on the last pixel caused by a word.
//   Config port (cfg_we/cfg_index/cfg_wdata): write only while idle; any write
//   to a known register restarts the frame, the line store keeps its contents.
// Timing
//   Copy and shrink: one word per cycle unless the output stalls. Enlarge: a word
//   is taken, then F*F pixels are read from the line store one per cycle unless
//   the output stalls; no word is taken until the run is read, as the line store
//   has a single read port. Every output word passes the read stage and then the
//   output register. While the first row of a frame is captured no pixels come out.
// Reset and stalls
//   rst_n (synchronous, active low) clears the registers and the frame state;
//   the line store is not cleared and needs no clearing pass. A stalled output
//   holds its word; reads stop and, once the read stage also holds a word,
//   in_ready drops until the sink takes it.

module nearest_neighbor_image_scaler
  import nnis_pkg::*;
#(
  parameter int MAX_WIDTH  = NNIS_MAX_WIDTH,
  parameter int MAX_FACTOR = NNIS_MAX_FACTOR
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // input words
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_opcode,
  input  logic [CHAN_W-1:0]     in_red_in,
  input  logic [CHAN_W-1:0]     in_green_in,
  input  logic [CHAN_W-1:0]     in_blue_in,
  // output words
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CHAN_W-1:0]     out_red_out,
  output logic [CHAN_W-1:0]     out_green_out,
  output logic [CHAN_W-1:0]     out_blue_out,
  output logic                  out_row_end,
  output logic                  out_run_last
);

  localparam int CW    = $clog2(MAX_WIDTH);          // column index
  localparam int WW    = $clog2(MAX_WIDTH + 1);      // effective width
  localparam int FW    = $clog2(MAX_FACTOR + 1);     // effective factor
  localparam int PW    = $clog2(MAX_FACTOR);         // phase counters
  localparam int KW    = $clog2(MAX_FACTOR * MAX_FACTOR); // emit countdown
  localparam int AW    = CW + 1;                     // bank + column
  localparam int DEPTH = 2 ** AW;                    // two halves of 2**CW

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [MODE_W-1:0]   scale_mode_r;
  logic [FACTOR_W-1:0] scale_factor_r;
  logic [WIDTH_W-1:0]  image_width_r;
  logic                cfg_hit;

  assign cfg_hit = cfg_we && (cfg_index == REG_SCALE_MODE ||
                              cfg_index == REG_SCALE_FACTOR ||
                              cfg_index == REG_IMAGE_WIDTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_mode_r   <= MODE_RST;
      scale_factor_r <= FACTOR_RST;
      image_width_r  <= WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCALE_MODE:   scale_mode_r   <= cfg_wdata[MODE_W-1:0];
        REG_SCALE_FACTOR: scale_factor_r <= cfg_wdata[FACTOR_W-1:0];
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped factor and width
  logic [FW-1:0]   f_eff;
  logic [WW-1:0]   w_eff;
  logic [2*FW-1:0] ff;

  always_comb begin
    if (scale_factor_r == '0)
      f_eff = FW'(1);
    else if (32'(scale_factor_r) > MAX_FACTOR)
      f_eff = FW'(MAX_FACTOR);
    else
      f_eff = FW'(scale_factor_r);

    if (image_width_r == '0)
      w_eff = WW'(1);
    else if (32'(image_width_r) > MAX_WIDTH)
      w_eff = WW'(MAX_WIDTH);
    else
      w_eff = WW'(image_width_r);
  end

  assign ff = (2*FW)'(f_eff) * (2*FW)'(f_eff);

  // ---------------------------------------------------------------------
  // Frame state
  // ---------------------------------------------------------------------
  logic          state_r, state_nxt;
  logic          bank_r, bank_nxt;          // line half being written
  logic          rd_bank_r, rd_bank_nxt;    // half being replayed
  logic          frs_r, frs_nxt;            // a full row is stored
  logic [CW-1:0] col_r, col_nxt;            // input column
  logic [PW-1:0] col_mod_r, col_mod_nxt;    // input column mod F
  logic [PW-1:0] row_phase_r, row_phase_nxt;
  logic [CW-1:0] src_r, src_nxt;            // replay source column
  logic [PW-1:0] sub_r, sub_nxt;            // copy within source column
  logic [KW-1:0] cnt_r, cnt_nxt;            // pixels left in this run

  // Pipeline: read stage (memory data register) then output register
  logic             p_vld_r, p_vld_nxt;
  logic             p_mem_r, p_mem_nxt;     // word comes from line store
  logic [PIX_W-1:0] p_pix_r, p_pix_nxt;
  logic             p_end_r, p_end_nxt;
  logic             p_last_r, p_last_nxt;

  logic             out_valid_r;
  logic [PIX_W-1:0] out_pix_r;
  logic             out_end_r;
  logic             out_last_r;

  logic out_adv, s2_adv, in_acc;

  assign out_adv  = !out_valid_r || out_ready;
  assign s2_adv   = !p_vld_r || out_adv;
  assign in_ready = (state_r == ST_IDLE) && s2_adv;
  assign in_acc   = in_valid && in_ready;

  // Line store ports
  logic [PIX_W-1:0] line_mem [DEPTH];
  logic             wr_en, rd_en;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic [PIX_W-1:0] wr_data;
  logic [PIX_W-1:0] rd_data_r;

  // Decoded input word
  logic             is_flush, row_done, step_col;
  logic [PIX_W-1:0] in_pix;
  logic             emit_end, col_step_wrap, sub_wrap;

  assign is_flush = (in_opcode == OP_FLUSH);
  assign in_pix   = {in_red_in, in_green_in, in_blue_in};
  assign row_done = (WW'(col_r) + WW'(1)) >= w_eff;

  // Replay position: end of output row when the last copy of the last column
  assign sub_wrap = (FW'(sub_r) + FW'(1)) >= f_eff;
  assign emit_end = sub_wrap && (WW'(src_r) == w_eff - WW'(1));
  assign col_step_wrap = (FW'(col_mod_r) + FW'(1)) >= f_eff;

  always_comb begin
    state_nxt     = state_r;
    bank_nxt      = bank_r;
    rd_bank_nxt   = rd_bank_r;
    frs_nxt       = frs_r;
    col_nxt       = col_r;
    col_mod_nxt   = col_mod_r;
    row_phase_nxt = row_phase_r;
    src_nxt       = src_r;
    sub_nxt       = sub_r;
    cnt_nxt       = cnt_r;

    p_vld_nxt  = p_vld_r;
    p_mem_nxt  = p_mem_r;
    p_pix_nxt  = p_pix_r;
    p_end_nxt  = p_end_r;
    p_last_nxt = p_last_r;
    if (s2_adv) p_vld_nxt = 1'b0;

    wr_en    = 1'b0;
    wr_addr  = {bank_r, col_r};
    wr_data  = is_flush ? '0 : in_pix;
    rd_en    = 1'b0;
    rd_addr  = {rd_bank_r, src_r};
    step_col = 1'b0;

    if (cfg_hit) begin
      // restart the frame; line store keeps its contents
      state_nxt     = ST_IDLE;
      bank_nxt      = 1'b0;
      frs_nxt       = 1'b0;
      col_nxt       = '0;
      col_mod_nxt   = '0;
      row_phase_nxt = '0;
      src_nxt       = '0;
      sub_nxt       = '0;
    end else if (state_r == ST_EMIT) begin
      if (s2_adv) begin
        rd_en      = 1'b1;
        p_vld_nxt  = 1'b1;
        p_mem_nxt  = 1'b1;
        p_end_nxt  = emit_end;
        p_last_nxt = (cnt_r == '0);
        if (emit_end) begin
          src_nxt = '0;
          sub_nxt = '0;
        end else if (sub_wrap) begin
          src_nxt = src_r + CW'(1);
          sub_nxt = '0;
        end else begin
          sub_nxt = sub_r + PW'(1);
        end
        cnt_nxt = cnt_r - KW'(1);
        if (cnt_r == '0) state_nxt = ST_IDLE;
      end
    end else if (in_acc) begin
      case (scale_mode_r)
        MODE_ENLARGE: begin
          if (!(is_flush && !frs_r)) begin
            wr_en    = 1'b1;
            step_col = 1'b1;
            if (frs_r) begin
              state_nxt   = ST_EMIT;
              rd_bank_nxt = ~bank_r;
              cnt_nxt     = KW'(ff - (2*FW)'(1));
            end
            if (row_done) begin
              if (is_flush) begin
                frs_nxt = 1'b0;
              end else begin
                bank_nxt = ~bank_r;
                frs_nxt  = 1'b1;
              end
            end
          end
        end
        MODE_SHRINK: begin
          if (!is_flush) begin
            step_col = 1'b1;
            if (row_phase_r == '0 && col_mod_r == '0) begin
              p_vld_nxt  = 1'b1;
              p_mem_nxt  = 1'b0;
              p_pix_nxt  = in_pix;
              // last kept column: no further kept column fits in the row
              p_end_nxt  = (32'(col_r) + 32'(f_eff)) >= 32'(w_eff);
              p_last_nxt = 1'b1;
            end
            if (row_done) begin
              if ((FW'(row_phase_r) + FW'(1)) >= f_eff)
                row_phase_nxt = '0;
              else
                row_phase_nxt = row_phase_r + PW'(1);
            end
          end
        end
        default: begin
          // copy, and the unused mode code
          if (!is_flush) begin
            step_col   = 1'b1;
            p_vld_nxt  = 1'b1;
            p_mem_nxt  = 1'b0;
            p_pix_nxt  = in_pix;
            p_end_nxt  = row_done;
            p_last_nxt = 1'b1;
          end
        end
      endcase

      if (step_col) begin
        if (row_done) begin
          col_nxt     = '0;
          col_mod_nxt = '0;
        end else begin
          col_nxt     = col_r + CW'(1);
          col_mod_nxt = col_step_wrap ? '0 : col_mod_r + PW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bank_r      <= 1'b0;
      rd_bank_r   <= 1'b0;
      frs_r       <= 1'b0;
      col_r       <= '0;
      col_mod_r   <= '0;
      row_phase_r <= '0;
      src_r       <= '0;
      sub_r       <= '0;
      cnt_r       <= '0;
      p_vld_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bank_r      <= bank_nxt;
      rd_bank_r   <= rd_bank_nxt;
      frs_r       <= frs_nxt;
      col_r       <= col_nxt;
      col_mod_r   <= col_mod_nxt;
      row_phase_r <= row_phase_nxt;
      src_r       <= src_nxt;
      sub_r       <= sub_nxt;
      cnt_r       <= cnt_nxt;
      p_vld_r     <= p_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_mem_r  <= p_mem_nxt;
    p_pix_r  <= p_pix_nxt;
    p_end_r  <= p_end_nxt;
    p_last_r <= p_last_nxt;
  end

  // ---------------------------------------------------------------------
  // Line store: ping-pong halves, one write and one registered read
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (wr_en) line_mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= line_mem[rd_addr];
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && p_vld_r) begin
      out_pix_r  <= p_mem_r ? rd_data_r : p_pix_r;
      out_end_r  <= p_end_r;
      out_last_r <= p_last_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red_out   = out_pix_r[PIX_W-1 -: CHAN_W];
  assign out_green_out = out_pix_r[CHAN_W +: CHAN_W];
  assign out_blue_out  = out_pix_r[CHAN_W-1:0];
  assign out_row_end   = out_end_r;
  assign out_run_last  = out_last_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // a line store read lands in the read stage as a memory word
  a_read_lands: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> (p_vld_r && p_mem_r))
    else $error("line store read did not reach the read stage");

  // the countdown never exceeds one run of F*F pixels
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (32'(cnt_r) < 32'(ff)))
    else $error("emit countdown beyond F*F");

  // replay never reads past the row
  a_src_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (WW'(src_r) < w_eff))
    else $error("replay column beyond image width");

  // the last word of a run leaves the sequencer idle
  a_run_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && cnt_r == '0 && !cfg_hit) |=> (state_r == ST_IDLE))
    else $error("sequencer still busy after last pixel of a run");

endmodule

@@ tb/sv/nearest_neighbor_image_scaler_tb.sv @@
// Self-checking testbench for the nearest-neighbor image scaler in copy, enlarge and shrink modes.
`timescale 1ns / 1ps

module nearest_neighbor_image_scaler_tb;
  import nnis_pkg::*;

  localparam int MAX_W = NNIS_MAX_WIDTH;
  localparam int MAX_F = NNIS_MAX_FACTOR;

  // Spare mode code, must behave as copy
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // Idle time before a register write: covers a full F*F burst plus pipeline
  localparam int SETTLE_CYCLES = 100;
  // Cycles without any handshake before the run is declared hung
  localparam int STALL_LIMIT   = 4000;
  // Cap on printed mismatch lines
  localparam int MAX_REPORTS   = 50;

  typedef struct packed {
    logic              opcode;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_word_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              row_end;
    logic              run_last;
  } out_pixel_t;

  // ---------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = REG_SCALE_MODE;
  logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
  logic                  in_valid    = 1'b0;
  logic                  in_opcode   = OP_PIXEL;
  logic [CHAN_W-1:0]     in_red_in   = '0;
  logic [CHAN_W-1:0]     in_green_in = '0;
  logic [CHAN_W-1:0]     in_blue_in  = '0;
  logic                  out_ready   = 1'b0;
  logic                  in_ready;
  logic                  out_valid;
  logic [CHAN_W-1:0]     out_red_out;
  logic [CHAN_W-1:0]     out_green_out;
  logic [CHAN_W-1:0]     out_blue_out;
  logic                  out_row_end;
  logic                  out_run_last;

  nearest_neighbor_image_scaler dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_red_in    (in_red_in),
    .in_green_in  (in_green_in),
    .in_blue_in   (in_blue_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_red_out  (out_red_out),
    .out_green_out(out_green_out),
    .out_blue_out (out_blue_out),
    .out_row_end  (out_row_end),
    .out_run_last (out_run_last)
  );

  // 4 ns period
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------------------
  // Bookkeeping
  // ---------------------------------------------------------------------------
  pixel_word_t word_queue[$];     // words waiting for the driver
  out_pixel_t  pixel_expect[$];   // predicted output pixels, oldest first

  int words_queued   = 0;
  int words_taken    = 0;
  int pixels_checked = 0;
  int error_count    = 0;
  int settings_run   = 0;
  int idle_cycles    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  logic took_word    = 1'b0;      // current word was taken at the last rising edge

  // ---------------------------------------------------------------------------
  // Scaler predictor: register copy plus frame state
  // ---------------------------------------------------------------------------
  logic [MODE_W-1:0]   sc_mode;
  logic [FACTOR_W-1:0] sc_factor;
  logic [WIDTH_W-1:0]  sc_width;
  bit   [PIX_W-1:0]    line_mem [2*MAX_W];  // ping-pong halves: [0..MAX_W-1], [MAX_W..]
  logic                bank_sel;            // half being written
  logic                row_stored;          // the other half holds a complete row
  int unsigned         col_ptr;             // input column
  int unsigned         row_phase;           // shrink: input row modulo F
  int unsigned         out_col;             // enlarge: column within output row

  function automatic int unsigned clamp_factor(logic [FACTOR_W-1:0] f);
    if (f == 0) return 1;
    if (f > MAX_F) return MAX_F;
    return f;
  endfunction

  function automatic int unsigned clamp_width(logic [WIDTH_W-1:0] w);
    if (w == 0) return 1;
    if (w > MAX_W) return MAX_W;
    return w;
  endfunction

  // A write to a known register (and reset) starts a new frame; line_mem survives
  task automatic restart_frame();
    bank_sel   = 1'b0;
    row_stored = 1'b0;
    col_ptr    = 0;
    row_phase  = 0;
    out_col    = 0;
  endtask

  task automatic expect_pixel(logic [PIX_W-1:0] rgb, logic row_end, logic run_last);
    out_pixel_t p;
    p.red      = rgb[23:16];
    p.green    = rgb[15:8];
    p.blue     = rgb[7:0];
    p.row_end  = row_end;
    p.run_last = run_last;
    pixel_expect.push_back(p);
  endtask

  // Work out the pixels one accepted word produces and advance the frame state
  task automatic predict_scaled(logic opcode, logic [PIX_W-1:0] rgb);
    int unsigned f;
    int unsigned wd;
    int unsigned col;
    int unsigned src;
    int unsigned k;
    int unsigned last_kept;
    logic        is_flush;
    logic        row_done;
    f        = clamp_factor(sc_factor);
    wd       = clamp_width(sc_width);
    col      = (col_ptr >= wd) ? 0 : col_ptr;
    is_flush = (opcode == OP_FLUSH);
    row_done = (col + 1 >= wd);

    // Flush does nothing outside enlarge, or when no row is stored yet
    if (is_flush && (sc_mode != MODE_ENLARGE || !row_stored)) return;

    if (sc_mode == MODE_ENLARGE) begin
      // Replay F*F pixels of the stored row in output raster order
      if (row_stored) begin
        for (k = 0; k < f * f; k++) begin
          src = out_col / f;
          if (src >= MAX_W) src = MAX_W - 1;
          expect_pixel(line_mem[(bank_sel ? 0 : MAX_W) + src],
                       (out_col + 1 >= wd * f), (k == f * f - 1));
          out_col = (out_col + 1 >= wd * f) ? 0 : out_col + 1;
        end
      end
      // Flush leaves a black hole in the row being captured
      line_mem[(bank_sel ? MAX_W : 0) + col] = is_flush ? '0 : rgb;
      if (row_done) begin
        if (is_flush) begin
          row_stored = 1'b0;   // row closed by a flush is dropped
        end else begin
          bank_sel   = ~bank_sel;
          row_stored = 1'b1;
        end
      end
    end else if (sc_mode == MODE_SHRINK) begin
      if (row_phase == 0 && (col % f) == 0) begin
        last_kept = ((wd - 1) / f) * f;
        expect_pixel(rgb, (col == last_kept), 1'b1);
      end
      if (row_done) row_phase = (row_phase + 1 >= f) ? 0 : row_phase + 1;
    end else begin
      // copy, and the spare mode code
      expect_pixel(rgb, row_done, 1'b1);
    end
    col_ptr = row_done ? 0 : col + 1;
  endtask

  task automatic report_mismatch(string what, int got, int want);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("MISMATCH @%0t pixel %0d: %s got %0h expected %0h",
               $realtime, pixels_checked, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: register writes, accepted words and output pixels at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    out_pixel_t want;
    if (!rst_n) begin
      sc_mode   = MODE_RST;
      sc_factor = FACTOR_RST;
      sc_width  = WIDTH_RST;
      restart_frame();
      took_word <= 1'b0;
    end else begin
      took_word <= in_valid && in_ready;

      if (cfg_we) begin
        case (cfg_index)
          REG_SCALE_MODE:   sc_mode   = cfg_wdata[MODE_W-1:0];
          REG_SCALE_FACTOR: sc_factor = cfg_wdata[FACTOR_W-1:0];
          REG_IMAGE_WIDTH:  sc_width  = cfg_wdata[WIDTH_W-1:0];
          default: ;
        endcase
        if (cfg_index <= REG_IMAGE_WIDTH) restart_frame();
      end

      // Check before predicting: pixels out now belong to older words
      if (out_valid && out_ready) begin
        if (pixel_expect.size() == 0) begin
          report_mismatch("pixel with nothing pending, rgb",
                          {out_red_out, out_green_out, out_blue_out}, 0);
        end else begin
          want = pixel_expect.pop_front();
          if (out_red_out !== want.red)     report_mismatch("red", out_red_out, want.red);
          if (out_green_out !== want.green) report_mismatch("green", out_green_out, want.green);
          if (out_blue_out !== want.blue)   report_mismatch("blue", out_blue_out, want.blue);
          if (out_row_end !== want.row_end)
            report_mismatch("row_end", out_row_end, want.row_end);
          if (out_run_last !== want.run_last)
            report_mismatch("run_last", out_run_last, want.run_last);
        end
        pixels_checked++;
      end

      if (in_valid && in_ready) begin
        predict_scaled(in_opcode, {in_red_in, in_green_in, in_blue_in});
        words_taken++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: presents queued words at the falling edge, holds each until taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : driver
    pixel_word_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || took_word) begin
      if (word_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = word_queue.pop_front();
        in_valid    <= 1'b1;
        in_opcode   <= nxt.opcode;
        in_red_in   <= nxt.red;
        in_green_in <= nxt.green;
        in_blue_in  <= nxt.blue;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Sink backpressure
  always @(negedge clk) begin
    if (rst_n) out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: no handshake of any kind for too long means a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles, %0d pixels pending",
                 idle_cycles, pixel_expect.size());
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Channel value biased toward the extremes
  function automatic logic [CHAN_W-1:0] rand_chan();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return CHAN_W'($urandom);
    endcase
  endfunction

  task automatic queue_word(logic opcode, logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                            logic [CHAN_W-1:0] b);
    pixel_word_t w;
    w.opcode = opcode;
    w.red    = r;
    w.green  = g;
    w.blue   = b;
    word_queue.push_back(w);
    words_queued++;
  endtask

  // Block until every queued word is taken and every predicted pixel has come
  task automatic wait_drained();
    do @(negedge clk);
    while (words_taken != words_queued || pixel_expect.size() != 0);
  endtask

  // Register writes only on an idle block; flushes and first-row words may
  // still be in flight with nothing pending, hence the settle time
  task automatic program_scaler(logic [MODE_W-1:0] mode, logic [FACTOR_W-1:0] factor,
                                logic [WIDTH_W-1:0] width);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SCALE_MODE;
    cfg_wdata <= CFG_DATA_W'(mode);
    @(negedge clk);
    cfg_index <= REG_SCALE_FACTOR;
    cfg_wdata <= CFG_DATA_W'(factor);
    @(negedge clk);
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_wdata <= CFG_DATA_W'(width);
    @(negedge clk);
    cfg_we    <= 1'b0;
    settings_run++;
  endtask

  // Enlarge: mostly whole rows, some closed by a flush, some holes and strays.
  // Copy/shrink: pixels with a sprinkling of flushes that must be ignored.
  task automatic gen_words(logic [MODE_W-1:0] mode, logic [WIDTH_W-1:0] width, int count);
    int unsigned wd;
    int unsigned c;
    int          made;
    wd   = clamp_width(width);
    made = 0;
    if (mode == MODE_ENLARGE) begin
      while (made < count) begin
        if ($urandom_range(19) == 0) queue_word(OP_FLUSH, rand_chan(), rand_chan(), rand_chan());
        for (c = 0; c < wd; c++) begin
          queue_word(($urandom_range(99) < ((c == wd - 1) ? 15 : 5)) ? OP_FLUSH : OP_PIXEL,
                     rand_chan(), rand_chan(), rand_chan());
          made++;
        end
      end
    end else begin
      while (made < count) begin
        if ($urandom_range(11) == 0) begin
          queue_word(OP_FLUSH, rand_chan(), rand_chan(), rand_chan());
        end else begin
          queue_word(OP_PIXEL, rand_chan(), rand_chan(), rand_chan());
          made++;
        end
      end
    end
  endtask

  task automatic run_phase(logic [MODE_W-1:0] mode, logic [FACTOR_W-1:0] factor,
                           logic [WIDTH_W-1:0] width, int count);
    program_scaler(mode, factor, width);
    gen_words(mode, width, count);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    // sender idles lightly, sink stalls heavily
    send_idle_pct  = 13;
    recv_stall_pct = 69;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings (copy, width 640): extremes, and a flush that is ignored
    queue_word(OP_PIXEL, 8'h00, 8'h00, 8'h00);
    queue_word(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    queue_word(OP_FLUSH, 8'hFF, 8'hFF, 8'hFF);
    queue_word(OP_PIXEL, 8'hA5, 8'h5A, 8'hC3);

    // Enlarge x2, 3 wide
    program_scaler(MODE_ENLARGE, 4'd2, 12'd3);
    queue_word(OP_FLUSH, 8'h12, 8'h34, 8'h56);               // nothing stored: ignored
    queue_word(OP_PIXEL, 8'h11, 8'h22, 8'h33);               // first row: silent capture
    queue_word(OP_PIXEL, 8'hFF, 8'h00, 8'hFF);
    queue_word(OP_PIXEL, 8'h00, 8'hFF, 8'h00);
    queue_word(OP_FLUSH, 8'hEE, 8'hEE, 8'hEE);               // emits, leaves a black hole
    queue_word(OP_PIXEL, 8'h44, 8'h55, 8'h66);
    queue_word(OP_PIXEL, 8'h77, 8'h88, 8'h99);               // row closed by pixel: kept
    queue_word(OP_PIXEL, 8'hAA, 8'hBB, 8'hCC);
    queue_word(OP_PIXEL, 8'hDD, 8'hEE, 8'hFF);
    queue_word(OP_FLUSH, 8'h01, 8'h02, 8'h03);               // row closed by flush: dropped
    queue_word(OP_FLUSH, 8'h04, 8'h05, 8'h06);               // nothing stored again

    // Shrink /2, 3 wide: keep columns 0 and 2 of even rows
    program_scaler(MODE_SHRINK, 4'd2, 12'd3);
    repeat (3) queue_word(OP_PIXEL, rand_chan(), rand_chan(), rand_chan());
    queue_word(OP_FLUSH, 8'hFF, 8'hFF, 8'hFF);
    repeat (3) queue_word(OP_PIXEL, rand_chan(), rand_chan(), rand_chan());

    // Spare mode code acts as copy
    program_scaler(MODE_UNUSED, 4'd2, 12'd2);
    repeat (2) queue_word(OP_PIXEL, rand_chan(), rand_chan(), rand_chan());

    // Random part, first idle pattern
    run_phase(MODE_COPY, 4'd1, 12'd5, 25);
    run_phase(MODE_ENLARGE, 4'd3, 12'd4, 40);
    run_phase(MODE_SHRINK, 4'd3, 12'd7, 20);
    wait_drained();                                          // sender holds until all out
    gen_words(MODE_SHRINK, 12'd7, 20);
    run_phase(MODE_ENLARGE, 4'd1, 12'd6, 25);                // one-row-delayed copy
    run_phase(MODE_ENLARGE, 4'd0, 12'd3, 20);                // factor 0 acts as 1

    // Swap: sender idles heavily, sink stalls lightly
    wait_drained();
    send_idle_pct  = 69;
    recv_stall_pct = 13;
    run_phase(MODE_ENLARGE, 4'd15, 12'd2, 20);               // factor clamps to 8
    run_phase(MODE_SHRINK, 4'd8, 12'd20, 25);
    run_phase(MODE_SHRINK, 4'd15, 12'd9, 25);
    run_phase(MODE_UNUSED, 4'd2, 12'd0, 15);                 // width 0 acts as 1
    run_phase(MODE_COPY, 4'd4, 12'd4095, 20);                // width clamps to max

    // Full rate on both sides
    wait_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_phase(MODE_SHRINK, 4'd2, 12'd4095, 20);
    run_phase(MODE_COPY, 4'd2, 12'd2048, 10);
    run_phase(MODE_ENLARGE, 4'd8, 12'd1, 15);                // 64 pixels per word
    repeat (3)
      run_phase(MODE_ENLARGE, FACTOR_W'($urandom_range(6, 2)),
                WIDTH_W'($urandom_range(10, 1)), 25);
    repeat (2)
      run_phase(MODE_SHRINK, FACTOR_W'($urandom_range(MAX_F, 1)),
                WIDTH_W'($urandom_range(24, 1)), 20);

    // Let everything come out, then watch for strays
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Run covered %0d input words and %0d output pixels over %0d scaler settings,",
             words_taken, pixels_checked, settings_run);
    $display("with copy, enlarge x1..x8 incl. flushed rows, shrink, and clamped settings.");
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", error_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
